[sv/uesc_pkg.sv]
// ----------------------------------------------------------------------------
// Escape decoder package
// Item types, the bundle that links the front and back parts, and constants
// shared by the escape-to-UTF-8 decoder.
// ----------------------------------------------------------------------------
package uesc_pkg;

   // Width of the capacity register and of the length counters.
   localparam int CAP_W = 16;

   // Capacity after reset, in bytes.
   localparam logic [CAP_W-1:0] CAP_RESET = 16'd1024;

   // Number of bundles the queue between front and back can hold.
   localparam int BUNDLE_DEPTH = 4;

   // Most result items that one input item can cause.
   localparam int MAX_ITEMS = 4;

   // One input item.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_item_type;

   // One result item.
   typedef struct packed {
      logic [7:0]       out_byte;
      logic             out_last;
      logic             error_flag;
      logic [CAP_W-1:0] out_length;
   } rsp_item_type;

   // All results of one input item. The final entry is an error item when
   // error is set, and carries the stream length when stream_end is set.
   typedef struct packed {
      logic [2:0]                 count;
      logic [MAX_ITEMS-1:0][7:0]  data;
      logic                       stream_end;
      logic                       error;
      logic [CAP_W-1:0]           length;
   } bundle_type;

endpackage

[sv/uesc_fifo.sv]
// ----------------------------------------------------------------------------
// Bundle queue
// A small register queue that parts the classifying front from the
// serialising back, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module uesc_fifo #(
   parameter int DEPTH = uesc_pkg::BUNDLE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  uesc_pkg::bundle_type push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output uesc_pkg::bundle_type pop_data
);
   import uesc_pkg::*;

   // DEPTH must be a power of two so the pointers wrap; it is not checked.
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bundle_type             slot_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff;
   logic [PTR_W-1:0]       rd_ptr_ff;
   logic [CNT_W-1:0]       count_ff;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   // Storage is written without reset; only filled slots are ever read.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

[sv/uesc_front.sv]
// ----------------------------------------------------------------------------
// Escape decoder front
// Holds the stream state, matches the escape prefix, gathers hex digits,
// checks capacity and packs all results of one item into a bundle.
// ----------------------------------------------------------------------------
module uesc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [uesc_pkg::CAP_W-1:0]    csr_data,
   input  logic                          req_push,
   output logic                          req_full,
   input  uesc_pkg::req_item_type        req_item,
   output logic                          bnd_push,
   output uesc_pkg::bundle_type          bnd_data,
   input  logic                          bnd_full
);
   import uesc_pkg::*;

   // Prefix characters.
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_FIVE    = 8'h35;
   localparam logic [7:0] CH_C_UP    = 8'h43;
   localparam logic [7:0] CH_C_LO    = 8'h63;
   localparam logic [7:0] CH_U_UP    = 8'h55;
   localparam logic [7:0] CH_U_LO    = 8'h75;

   // Escape progress: idle, or one more than the digits seen so far.
   localparam logic [2:0] HEX_IDLE  = 3'd0;
   localparam logic [2:0] HEX_FIRST = 3'd1;
   localparam logic [2:0] HEX_LAST  = 3'd4;

   localparam logic [1:0] STAGE_NONE = 2'd0;
   localparam logic [1:0] STAGE_ONE  = 2'd1;
   localparam logic [1:0] STAGE_FULL = 2'd3;

   logic [CAP_W-1:0] cap_ff;
   logic [1:0]       stage_ff, stage_in;
   logic [2:0]       hex_ff, hex_in;
   logic [11:0]      code_ff, code_in;
   logic [CAP_W-1:0] bw_ff, bw_in;
   logic             drop_ff, drop_in;
   logic             start_ff, start_in;
   logic [7:0]       held_ff [3];

   logic [7:0]       in_b;
   logic             in_last;
   logic             accept;
   logic             dig_ok;
   logic [3:0]       dig_val;
   logic             pfx_match;
   logic [CAP_W:0]   room_diff;
   logic [2:0]       avail;
   logic             room_ok;
   logic [15:0]      ucode;
   logic             fail;
   logic [2:0]       n_emit;
   logic [2:0]       n_lit;
   logic             lit_append;
   logic [MAX_ITEMS-1:0][7:0] emit_bytes;
   logic [MAX_ITEMS-1:0][7:0] lit_bytes;
   logic             held_we;
   logic [1:0]       held_idx;

   assign in_b      = req_item.in_byte;
   assign in_last   = req_item.in_last;
   assign req_full  = bnd_full;
   assign accept    = req_push && !bnd_full;
   assign csr_ready = 1'b1;

   // Hex digit decode.
   always_comb begin
      dig_ok  = 1'b1;
      dig_val = 4'd0;
      if (in_b >= 8'h30 && in_b <= 8'h39) begin
         dig_val = 4'(in_b - 8'h30);
      end else if (in_b >= 8'h41 && in_b <= 8'h46) begin
         dig_val = 4'(in_b - 8'h37);
      end else if (in_b >= 8'h61 && in_b <= 8'h66) begin
         dig_val = 4'(in_b - 8'h57);
      end else begin
         dig_ok = 1'b0;
      end
   end

   // Does this byte extend the prefix held so far?
   always_comb begin
      case (stage_ff)
         2'd0:    pfx_match = (in_b == CH_PERCENT);
         2'd1:    pfx_match = (in_b == CH_FIVE);
         2'd2:    pfx_match = (in_b == CH_C_UP) || (in_b == CH_C_LO);
         2'd3:    pfx_match = (in_b == CH_U_UP) || (in_b == CH_U_LO);
         default: pfx_match = 1'b0;
      endcase
   end

   // Free room: clipped to the four bytes one item can need.
   assign room_diff = {1'b0, cap_ff} - {1'b0, bw_ff};
   always_comb begin
      if (room_diff[CAP_W]) begin
         avail = 3'd0;
      end else if (room_diff[CAP_W-1:0] >= CAP_W'(MAX_ITEMS)) begin
         avail = 3'(MAX_ITEMS);
      end else begin
         avail = room_diff[2:0];
      end
   end
   assign room_ok = ({1'b0, cap_ff} >= ({1'b0, bw_ff} + (CAP_W+1)'(6)));
   assign ucode   = {code_ff, dig_val};

   // Literal bytes: the held prefix, then possibly the byte itself. Nothing
   // goes out while the prefix is still growing inside the stream.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         lit_bytes[k] = (2'(k) < stage_ff) ? held_ff[k] : in_b;
      end
      lit_bytes[3] = in_b;
      lit_append = pfx_match ? in_last : ((in_b != CH_PERCENT) || in_last);
      n_lit      = (pfx_match && !in_last) ? 3'd0
                                           : ({1'b0, stage_ff} + {2'b00, lit_append});
   end

   // Main step: next state and the bytes this item emits.
   always_comb begin
      fail       = 1'b0;
      n_emit     = 3'd0;
      emit_bytes = lit_bytes;
      stage_in   = stage_ff;
      hex_in     = hex_ff;
      code_in    = code_ff;
      bw_in      = bw_ff;
      drop_in    = drop_ff;
      start_in   = start_ff;
      held_we    = 1'b0;
      held_idx   = stage_ff;

      if (drop_ff) begin
         if (in_last) begin
            drop_in  = 1'b0;
            start_in = 1'b1;
            bw_in    = '0;
         end
      end else begin
         start_in = 1'b0;
         if (start_ff && (in_last || cap_ff <= CAP_W'(1))) begin
            fail = 1'b1;
         end else if (hex_ff != HEX_IDLE) begin
            if (!dig_ok) begin
               fail = 1'b1;
            end else if (hex_ff == HEX_LAST) begin
               hex_in = HEX_IDLE;
               if (!room_ok) begin
                  fail = 1'b1;
               end else if (ucode <= 16'h007F) begin
                  n_emit        = 3'd1;
                  emit_bytes[0] = {1'b0, ucode[6:0]};
               end else if (ucode <= 16'h07FF) begin
                  n_emit        = 3'd2;
                  emit_bytes[0] = {3'b110, ucode[10:6]};
                  emit_bytes[1] = {2'b10, ucode[5:0]};
               end else begin
                  n_emit        = 3'd3;
                  emit_bytes[0] = {4'b1110, ucode[15:12]};
                  emit_bytes[1] = {2'b10, ucode[11:6]};
                  emit_bytes[2] = {2'b10, ucode[5:0]};
               end
            end else begin
               hex_in  = hex_ff + 3'd1;
               code_in = {code_ff[7:0], dig_val};
               if (in_last) begin
                  fail = 1'b1;
               end
            end
         end else begin
            if (n_lit > avail) begin
               fail   = 1'b1;
               n_emit = avail;
            end else begin
               n_emit = n_lit;
            end
            stage_in = STAGE_NONE;
            if (!in_last) begin
               if (pfx_match && stage_ff == STAGE_FULL) begin
                  hex_in = HEX_FIRST;
               end else if (pfx_match) begin
                  stage_in = stage_ff + 2'd1;
                  held_we  = 1'b1;
               end else if (in_b == CH_PERCENT) begin
                  stage_in = STAGE_ONE;
                  held_we  = 1'b1;
                  held_idx = STAGE_NONE;
               end
            end
         end

         // Stream end or error: clear the per-stream state.
         if (fail || in_last) begin
            stage_in = STAGE_NONE;
            hex_in   = HEX_IDLE;
            held_we  = 1'b0;
         end
         if (in_last) begin
            start_in = 1'b1;
            bw_in    = '0;
         end else if (fail) begin
            drop_in = 1'b1;
         end else begin
            bw_in = bw_ff + CAP_W'(n_emit);
         end
      end
   end

   // Bundle for the back part.
   always_comb begin
      bnd_data            = '0;
      bnd_data.count      = n_emit + {2'b00, fail};
      bnd_data.data       = emit_bytes;
      bnd_data.stream_end = in_last || fail;
      bnd_data.error      = fail;
      bnd_data.length     = bw_ff + CAP_W'(n_emit);
   end
   assign bnd_push = accept && !drop_ff && (n_emit != 3'd0 || fail);

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_RESET;
         stage_ff <= STAGE_NONE;
         hex_ff   <= HEX_IDLE;
         bw_ff    <= '0;
         drop_ff  <= 1'b0;
         start_ff <= 1'b1;
      end else begin
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_data;
         end
         if (accept) begin
            stage_ff <= stage_in;
            hex_ff   <= hex_in;
            bw_ff    <= bw_in;
            drop_ff  <= drop_in;
            start_ff <= start_in;
         end
      end
   end

   // Payload state: the digit shift register and the held prefix bytes.
   always_ff @(posedge clock) begin
      if (accept) begin
         code_ff <= code_in;
         if (held_we) begin
            held_ff[held_idx] <= in_b;
         end
      end
   end

   // A stream is never inside an escape and a prefix at once.
   a_escape_or_prefix : assert property (@(posedge clock) disable iff (reset)
      (hex_ff != HEX_IDLE) |-> (stage_ff == STAGE_NONE))
      else $error("escape and prefix active together");

   // Escape progress never passes the fourth digit.
   a_hex_range : assert property (@(posedge clock) disable iff (reset)
      hex_ff <= HEX_LAST)
      else $error("hex digit count out of range");

   // While dropping, no escape or prefix is in progress.
   a_drop_clean : assert property (@(posedge clock) disable iff (reset)
      drop_ff |-> (hex_ff == HEX_IDLE && stage_ff == STAGE_NONE))
      else $error("stale escape state while dropping");

   // Written bytes stay within the capacity unless it was lowered.
   a_len_bound : assert property (@(posedge clock) disable iff (reset)
      (bnd_push && !bnd_data.error) |-> (bnd_data.length <= cap_ff))
      else $error("output length beyond capacity");

endmodule

[sv/uesc_back.sv]
// ----------------------------------------------------------------------------
// Escape decoder back
// Takes bundles from the queue and hands their result items out one per
// cycle, while the reader keeps taking them, through an output register.
// ----------------------------------------------------------------------------
module uesc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   bnd_valid,
   input  uesc_pkg::bundle_type   bnd_data,
   output logic                   bnd_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output uesc_pkg::rsp_item_type rsp_item
);
   import uesc_pkg::*;

   bundle_type   cur_ff;
   logic         cur_valid_ff;
   logic [1:0]   idx_ff;
   rsp_item_type out_ff;
   logic         out_valid_ff;

   logic         pop_acc;
   logic         out_load;
   logic         tail;
   logic         cur_done;
   rsp_item_type next_item;

   assign pop_acc   = rsp_pop && out_valid_ff;
   assign out_load  = cur_valid_ff && (!out_valid_ff || pop_acc);
   assign tail      = (({1'b0, idx_ff} + 3'd1) == cur_ff.count);
   assign cur_done  = out_load && tail;
   assign bnd_pop   = bnd_valid && (!cur_valid_ff || cur_done);
   assign rsp_empty = !out_valid_ff;
   assign rsp_item  = out_ff;

   // Build the item at the current place of the bundle.
   always_comb begin
      next_item            = '0;
      next_item.out_byte   = cur_ff.data[idx_ff];
      if (tail && cur_ff.error) begin
         next_item.out_byte   = 8'd0;
         next_item.out_last   = 1'b1;
         next_item.error_flag = 1'b1;
      end else if (tail && cur_ff.stream_end) begin
         next_item.out_last   = 1'b1;
         next_item.out_length = cur_ff.length;
      end
   end

   // Current bundle and place within it.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else if (bnd_pop) begin
         cur_valid_ff <= 1'b1;
         idx_ff       <= '0;
      end else if (cur_done) begin
         cur_valid_ff <= 1'b0;
      end else if (out_load) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (bnd_pop) begin
         cur_ff <= bnd_data;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (pop_acc) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff <= next_item;
      end
   end

   // A held bundle always has an item left at the current place.
   a_idx_in_range : assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> ({1'b0, idx_ff} < cur_ff.count))
      else $error("bundle place beyond its item count");

   // A bundle taken from the queue is held in the next cycle.
   a_pop_loads : assert property (@(posedge clock) disable iff (reset)
      bnd_pop |=> cur_valid_ff)
      else $error("queue popped but no bundle held");

   // A waiting result stays put until it is taken.
   a_out_hold : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_pop) |=> (out_valid_ff && $stable(out_ff)))
      else $error("waiting result changed before it was taken");

endmodule

[sv/unicode_escape_to_utf8_decoder.sv]
// ----------------------------------------------------------------------------
// Escape-to-UTF-8 stream decoder
// Turns "%5Cu" escapes with four hex digits into UTF-8 and copies all other
// bytes, checking the result against a programmable output capacity.
//
//   Channel   Ports                               Direction  Moves
//   request   req_push, req_full, req_item        in         one source byte
//   response  rsp_empty, rsp_pop, rsp_item        out        one result byte
//   control   csr_valid, csr_ready, csr_data      in         output capacity
//
// An input item is taken every cycle while the bundle queue has room; each
// item makes 0 to 4 result items, which the output register hands out one
// per cycle while rsp_pop takes them. A result passes the bundle queue, the
// held-bundle register and the output register before it shows on rsp_item.
// Reset is synchronous; it sets the capacity to 1024 and starts a new stream.
// A stalled response side fills the queue and then raises req_full.
// ----------------------------------------------------------------------------
module unicode_escape_to_utf8_decoder #(
   parameter int BUNDLE_DEPTH = uesc_pkg::BUNDLE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  uesc_pkg::req_item_type        req_item,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output uesc_pkg::rsp_item_type        rsp_item,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [uesc_pkg::CAP_W-1:0]    csr_data
);
   import uesc_pkg::*;

   logic       fifo_push;
   bundle_type fifo_in;
   logic       fifo_full;
   logic       fifo_pop;
   logic       fifo_not_empty;
   bundle_type fifo_out;

   // Front: classify each item and pack its results.
   uesc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_item  (req_item),
      .bnd_push  (fifo_push),
      .bnd_data  (fifo_in),
      .bnd_full  (fifo_full)
   );

   // Queue between the two halves.
   uesc_fifo #(
      .DEPTH (BUNDLE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data (fifo_in),
      .full      (fifo_full),
      .pop       (fifo_pop),
      .not_empty (fifo_not_empty),
      .pop_data  (fifo_out)
   );

   // Back: hand the results out one at a time.
   uesc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .bnd_valid (fifo_not_empty),
      .bnd_data  (fifo_out),
      .bnd_pop   (fifo_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

endmodule
